/* rtl/psdl_pkg.sv */
// Shared types and constants for the per-source datagram limiter.
// No dependencies; imported by the cell and the top level.
package psdl_pkg;

  localparam int unsigned Capacity = 16;
  localparam int unsigned OccW     = $clog2(Capacity + 1);
  localparam int unsigned KeyW     = 64;
  localparam int unsigned CountW   = 16;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned ActiveW  = 5;

  localparam logic [CfgIdxW-1:0] CfgDatagramLimit = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgActiveEntries = 1'b1;

  localparam logic [CountW-1:0]  LimitReset  = CountW'(8);
  localparam logic [ActiveW-1:0] ActiveReset = ActiveW'(16);

  typedef enum logic [1:0] {
    StIdle,
    StLookup,
    StShift
  } state_e;

  // per-cell strobes from the controller
  typedef struct packed {
    logic shift;  // take key/count from the next cell up
    logic load;   // write the probe key with a count of one
    logic inc;    // bump the count
  } cell_ctrl_t;

endpackage

/* rtl/per_source_datagram_limiter_top.sv */
// Per-source datagram limiter: a chain of table cells plus the controller.
// An input beat is taken only in the idle state; its result beat is registered
// from the lookup state, which waits there while the output is stalled. A miss
// into a full table first drops entries in the shift state, one a cycle, then appends.
// Reset: occupancy zero, limit 8, active entries 16; table contents are not
// cleared, no clearing pass.
module per_source_datagram_limiter_top import psdl_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [15:0]         source_family_i,
  input  logic [15:0]         source_port_i,
  input  logic [31:0]         source_ip_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                allowed_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  state_e              state_q, state_d;
  logic [OccW-1:0]     occ_q, occ_d;
  logic [CountW-1:0]   limit_q;
  logic [ActiveW-1:0]  active_q;
  logic [KeyW-1:0]     key_q;
  logic                out_valid_q, out_valid_d;
  logic                allowed_q, allowed_d;

  logic [OccW-1:0]     lim_eff;
  logic [Capacity-1:0] match, under, hit;
  logic                any_hit, slot_free;
  logic                do_inc, do_shift, do_load;

  cell_ctrl_t          cell_ctrl [Capacity];
  logic [KeyW-1:0]     cell_key  [Capacity];
  logic [CountW-1:0]   cell_cnt  [Capacity];

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q  <= LimitReset;
      active_q <= ActiveReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgDatagramLimit: limit_q  <= cfg_data_i;
        CfgActiveEntries: active_q <= cfg_data_i[ActiveW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (active_q == '0) begin
      lim_eff = OccW'(1);
    end else if (32'(active_q) > 32'(Capacity)) begin
      lim_eff = OccW'(Capacity);
    end else begin
      lim_eff = OccW'(active_q);
    end
  end

  // probe key held for the whole lookup / shift / append sequence
  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      key_q <= {source_family_i, source_port_i, source_ip_i};
    end
  end

  // cell chain
  for (genvar i = 0; i < Capacity; i++) begin : g_cell
    logic [KeyW-1:0]   nb_key;
    logic [CountW-1:0] nb_cnt;

    if (i == Capacity - 1) begin : g_end
      assign nb_key = cell_key[i];
      assign nb_cnt = cell_cnt[i];
    end else begin : g_mid
      assign nb_key = cell_key[i+1];
      assign nb_cnt = cell_cnt[i+1];
    end

    assign hit[i] = match[i] && (OccW'(i) < occ_q);

    assign cell_ctrl[i].shift = do_shift;
    assign cell_ctrl[i].load  = do_load && (occ_q == OccW'(i));
    assign cell_ctrl[i].inc   = do_inc && hit[i] && under[i];

    psdl_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (cell_ctrl[i]),
      .probe_key_i (key_q),
      .limit_i     (limit_q),
      .nb_key_i    (nb_key),
      .nb_count_i  (nb_cnt),
      .key_o       (cell_key[i]),
      .count_o     (cell_cnt[i]),
      .match_o     (match[i]),
      .under_o     (under[i])
    );
  end

  assign any_hit   = |hit;
  assign slot_free = !out_valid_q || !out_stall_i;

  // controller
  always_comb begin
    state_d     = state_q;
    occ_d       = occ_q;
    out_valid_d = out_valid_q && out_stall_i;
    allowed_d   = allowed_q;
    do_inc      = 1'b0;
    do_shift    = 1'b0;
    do_load     = 1'b0;
    case (state_q)
      StIdle: begin
        if (in_valid_i) state_d = StLookup;
      end
      StLookup: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          if (any_hit) begin
            allowed_d = |(hit & under);
            do_inc    = 1'b1;
            state_d   = StIdle;
          end else begin
            allowed_d = 1'b1;
            if (occ_q >= lim_eff) begin
              state_d = StShift;
            end else begin
              do_load = 1'b1;
              occ_d   = occ_q + OccW'(1);
              state_d = StIdle;
            end
          end
        end
      end
      StShift: begin
        // drop oldest entries one a cycle until lim-1 remain, then append
        if (occ_q > lim_eff - OccW'(1)) begin
          do_shift = 1'b1;
          occ_d    = occ_q - OccW'(1);
        end else begin
          do_load = 1'b1;
          occ_d   = occ_q + OccW'(1);
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      occ_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      occ_q       <= occ_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    allowed_q <= allowed_d;
  end

  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = out_valid_q;
  assign allowed_o   = allowed_q;

  // checks
  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(occ_q) <= 32'(Capacity))
    else $error("occupancy beyond capacity");

  a_unique_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StLookup) |-> $onehot0(hit))
    else $error("source key held in more than one live entry");

  a_accept_lookup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == StLookup))
    else $error("accepted beat not looked up");

  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == StLookup))
    else $error("result beat raised outside lookup");

endmodule

/* rtl/psdl_cell.sv */
// One table slot: source key and count, exact-match compare and limit test.
// Depends on psdl_pkg.
module psdl_cell import psdl_pkg::*; (
  input  logic              clk_i,
  input  cell_ctrl_t        ctrl_i,
  input  logic [KeyW-1:0]   probe_key_i,
  input  logic [CountW-1:0] limit_i,
  input  logic [KeyW-1:0]   nb_key_i,
  input  logic [CountW-1:0] nb_count_i,
  output logic [KeyW-1:0]   key_o,
  output logic [CountW-1:0] count_o,
  output logic              match_o,
  output logic              under_o
);

  logic [KeyW-1:0]   key_q, key_d;
  logic [CountW-1:0] count_q, count_d;

  always_comb begin
    key_d   = key_q;
    count_d = count_q;
    if (ctrl_i.load) begin
      key_d   = probe_key_i;
      count_d = CountW'(1);
    end else if (ctrl_i.shift) begin
      key_d   = nb_key_i;
      count_d = nb_count_i;
    end else if (ctrl_i.inc) begin
      count_d = count_q + CountW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    count_q <= count_d;
  end

  assign key_o   = key_q;
  assign count_o = count_q;
  assign match_o = (key_q == probe_key_i);
  assign under_o = (count_q < limit_i);

endmodule

/* tb/per_source_datagram_limiter_top_tb.sv */
// Self-checking testbench for per_source_datagram_limiter_top: per-source
// table predictor, verdict scoreboard, random valid/stall pacing.
// Depends on rtl/psdl_pkg.sv and the limiter RTL.
`timescale 1ns / 100ps

class limiter_scoreboard;
  typedef struct {
    logic [63:0] key;
    bit          allowed;
  } verdict_t;

  logic [63:0] src_key[psdl_pkg::Capacity];
  logic [15:0] src_count[psdl_pkg::Capacity];
  int unsigned fill;
  logic [15:0] limit;
  logic [4:0]  active;
  verdict_t    verdict_q[$];
  int unsigned errors;

  function new();
    fill   = 0;
    limit  = psdl_pkg::LimitReset;
    active = psdl_pkg::ActiveReset;
    errors = 0;
  endfunction

  function void write_reg(logic [psdl_pkg::CfgIdxW-1:0] idx, logic [15:0] data);
    case (idx)
      psdl_pkg::CfgDatagramLimit: limit = data;
      psdl_pkg::CfgActiveEntries: active = data[4:0];
      default: ;
    endcase
  endfunction

  function int unsigned pending();
    return verdict_q.size();
  endfunction

  // works out the verdict for one datagram and updates the source table
  function void note_datagram(logic [63:0] key);
    verdict_t    v;
    int unsigned span;
    int unsigned drop;
    v.key = key;
    span = (active == 0) ? 1 : ((active > psdl_pkg::Capacity) ? psdl_pkg::Capacity : active);
    for (int i = 0; i < fill; i++) begin
      if (src_key[i] == key) begin
        if (src_count[i] >= limit) begin
          v.allowed = 1'b0;
        end else begin
          src_count[i] = src_count[i] + 16'd1;
          v.allowed = 1'b1;
        end
        verdict_q.push_back(v);
        return;
      end
    end
    // miss: keep the newest span-1 entries, then append
    if (fill >= span) begin
      drop = fill - (span - 1);
      for (int i = 0; i < span - 1; i++) begin
        src_key[i]   = src_key[i + drop];
        src_count[i] = src_count[i + drop];
      end
      fill = span - 1;
    end
    src_key[fill]   = key;
    src_count[fill] = 16'd1;
    fill++;
    v.allowed = 1'b1;
    verdict_q.push_back(v);
  endfunction

  function void check_verdict(logic allowed);
    verdict_t want;
    if (verdict_q.size() == 0) begin
      errors++;
      if (errors <= 10) $display("%0t ERROR: verdict %b with none pending", $time, allowed);
      return;
    end
    want = verdict_q.pop_front();
    if (allowed !== want.allowed) begin
      errors++;
      if (errors <= 10)
        $display("%0t ERROR: key %h allowed expected %b got %b",
                 $time, want.key, want.allowed, allowed);
    end
  endfunction
endclass

module per_source_datagram_limiter_top_tb;
  import psdl_pkg::*;

  localparam int unsigned ConfigSettle  = 40;
  localparam int unsigned StallLimit    = 2000;
  localparam int unsigned NumPhases     = 10;
  localparam int unsigned ItemsPerPhase = 100;
  localparam int unsigned PoolMax       = 24;

  localparam int unsigned PhaseLimit[NumPhases]  = '{1, 65535, 2, 0, 3, 4, 12, 1, 5, 2};
  localparam int unsigned PhaseActive[NumPhases] = '{16, 16, 1, 5, 31, 0, 20, 8, 16, 3};

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic [15:0]         source_family;
  logic [15:0]         source_port;
  logic [31:0]         source_ip;
  logic                out_valid;
  logic                out_stall;
  logic                allowed;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_data;

  limiter_scoreboard sb;
  bit                quiet;
  int unsigned       idle_cycles = 0;

  per_source_datagram_limiter_top dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .source_family_i (source_family),
    .source_port_i   (source_port),
    .source_ip_i     (source_ip),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .allowed_o       (allowed),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // monitor and watchdog
  always @(posedge clk) begin
    if (rst_n === 1'b1) begin
      if (cfg_we) sb.write_reg(cfg_idx, cfg_data);
      if (in_valid && !in_stall) sb.note_datagram({source_family, source_port, source_ip});
      if (out_valid && !out_stall) sb.check_verdict(allowed);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= StallLimit) begin
        $display("Test completed with failures");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // receiver stalls in bursts, with calm stretches between
  initial begin
    out_stall <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (!quiet && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 18)) @(posedge clk);
        out_stall <= 1'b0;
        repeat ($urandom_range(0, 40)) @(posedge clk);
      end
    end
  end

  function automatic logic [63:0] rand_key();
    return {16'($urandom), 16'($urandom), 32'($urandom)};
  endfunction

  task automatic send_datagram(input logic [63:0] key);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_valid <= 1'b1;
    {source_family, source_port, source_ip} <= key;
    do @(posedge clk); while (in_stall !== 1'b0);
  endtask

  // drain all verdicts, then let any eviction shift finish
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (ConfigSettle) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    logic [63:0]   k1;
    logic [63:0]   k2;
    logic [63:0]   base;
    logic [63:0]   key;
    logic [63:0]   pool[PoolMax];
    logic [15:0]   act_data;
    int unsigned   pool_n;

    sb          = new();
    quiet       = 1'b0;
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    source_family <= '0;
    source_port   <= '0;
    source_ip     <= '0;
    cfg_we        <= 1'b0;
    cfg_idx       <= CfgDatagramLimit;
    cfg_data      <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: field extremes, limit reached at reset settings
    send_datagram('0);
    send_datagram('1);
    k1 = {16'h0002, 16'h1234, 32'hC0A8_0001};
    repeat (9) send_datagram(k1);
    send_datagram({16'hFFFF, k1[47:0]});   // same port/ip, other family
    send_datagram({k1[63:48], 16'hFFFF, k1[31:0]});

    // zero limit: known sources refused, new ones accepted once
    settle();
    write_reg(CfgDatagramLimit, 16'd0);
    send_datagram(k1);
    k2 = {16'h000A, 16'h0000, 32'hFFFF_FFFF};
    send_datagram(k2);
    send_datagram(k2);

    // limit lowered below an existing count keeps the source blocked
    settle();
    write_reg(CfgDatagramLimit, 16'd3);
    send_datagram(k1);

    // active entries of zero acts as one; table shrinks on next insert
    settle();
    write_reg(CfgActiveEntries, 16'd0);
    send_datagram(rand_key());
    send_datagram(k1);
    send_datagram(k1);

    for (int p = 0; p < NumPhases; p++) begin
      settle();
      write_reg(CfgDatagramLimit, 16'(PhaseLimit[p]));
      act_data = 16'(PhaseActive[p]);
      if ($urandom_range(0, 1) == 1) act_data[15:5] = 11'($urandom);
      write_reg(CfgActiveEntries, act_data);
      if (p >= NumPhases - 2) quiet = 1'b1;

      // small key pool, entries often differing in one field only
      pool_n = $urandom_range(1, PoolMax);
      base   = rand_key();
      for (int i = 0; i < pool_n; i++) begin
        case ($urandom_range(0, 3))
          0:       pool[i] = rand_key();
          1:       pool[i] = {16'($urandom), base[47:0]};
          2:       pool[i] = {base[63:48], 16'($urandom), base[31:0]};
          default: pool[i] = {base[63:32], 32'($urandom)};
        endcase
      end

      repeat (ItemsPerPhase) begin
        if ($urandom_range(0, 9) == 0) key = rand_key();
        else key = pool[$urandom_range(0, pool_n - 1)];
        send_datagram(key);
      end
    end

    settle();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* per_source_datagram_limiter_top.f */
rtl/psdl_pkg.sv
rtl/psdl_cell.sv
rtl/per_source_datagram_limiter_top.sv
tb/per_source_datagram_limiter_top_tb.sv
